// ===== rtl/spfq_pkg.sv =====
// ---------------------------------------------------------------------------
// spfq_pkg: shared types and constants of the strict-priority FIFO queue
// Sizes, opcodes, request/response bundles and the free-list reset chain.
// ---------------------------------------------------------------------------
package spfq_pkg;

  localparam int CAPACITY   = 64;
  localparam int LEVELS     = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W   = 2;
  localparam int PRIO_W = 4;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [LVL_W-1:0]      lvl_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    data_t             payload;
  } req_t;

  typedef struct packed {
    logic  ok;
    data_t data;
    logic  empty;
  } rsp_t;

  // Link value of a slot that was never written: slots chain in index order.
  function automatic slot_t link_reset(slot_t idx);
    slot_t nxt;
    nxt = (idx == slot_t'(CAPACITY - 1)) ? '0 : slot_t'(idx + 1'b1);
    return nxt;
  endfunction

endpackage

// ===== rtl/spfq_ram.sv =====
// ---------------------------------------------------------------------------
// spfq_ram: generic single-write, single-read RAM
// Registered read, write-first when read and write hit the same address.
// ---------------------------------------------------------------------------
module spfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spfq_prio_enc.sv =====
// ---------------------------------------------------------------------------
// spfq_prio_enc: highest occupied level finder
// Level zero never holds entries and is skipped.
// ---------------------------------------------------------------------------
module spfq_prio_enc (
  input  logic [spfq_pkg::LEVELS-1:0] occ_i,
  output spfq_pkg::lvl_t              top_o,
  output logic                        found_o
);

  always_comb begin
    top_o   = '0;
    found_o = 1'b0;
    for (int i = 1; i < spfq_pkg::LEVELS; i++) begin
      if (occ_i[i]) begin
        top_o   = spfq_pkg::lvl_t'(i);
        found_o = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spfq_core.sv =====
// ---------------------------------------------------------------------------
// spfq_core: queue state and single-pass operation logic
// Level tables, free list, linked slot pool and prefetched slot reads.
// ---------------------------------------------------------------------------
module spfq_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  spfq_pkg::req_t   req_i,
  output spfq_pkg::rsp_t   rsp_o
);

  localparam int CAP = spfq_pkg::CAPACITY;
  localparam int LV  = spfq_pkg::LEVELS;

  spfq_pkg::slot_t free_q, free_d;
  spfq_pkg::slot_t first_q [LV];
  spfq_pkg::slot_t first_d [LV];
  spfq_pkg::slot_t last_q  [LV];
  spfq_pkg::slot_t last_d  [LV];
  logic [LV-1:0]   occ_q, occ_d;
  spfq_pkg::cnt_t  total_q, total_d;
  spfq_pkg::lvl_t  top_q, top_d;
  logic            top_vld_q, top_vld_d;
  spfq_pkg::slot_t head_q, head_d;
  logic [CAP-1:0]  link_vld_q, link_vld_d;
  logic            free_vld_q, pop_vld_q;

  logic            link_we;
  spfq_pkg::slot_t link_waddr, link_wdata;
  logic            data_we;
  spfq_pkg::data_t data_rd;
  spfq_pkg::slot_t free_rd, pop_rd;
  spfq_pkg::slot_t free_link, pop_link;

  spfq_pkg::lvl_t  lv;
  spfq_pkg::lvl_t  last_raddr;
  spfq_pkg::slot_t last_rd;
  logic            prio_ok;

  // Next links of the free head and of the served head, prefetched last cycle.
  assign free_link = free_vld_q ? free_rd : spfq_pkg::link_reset(free_q);
  assign pop_link  = pop_vld_q  ? pop_rd  : spfq_pkg::link_reset(head_q);

  assign lv         = spfq_pkg::lvl_t'(req_i.prio);
  assign prio_ok    = (req_i.prio != '0) && (int'(req_i.prio) < LV);
  assign last_raddr = (req_i.op == spfq_pkg::OP_PUSH) ? lv : top_q;
  assign last_rd    = last_q[last_raddr];

  always_comb begin
    free_d     = free_q;
    first_d    = first_q;
    last_d     = last_q;
    occ_d      = occ_q;
    total_d    = total_q;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    data_we    = 1'b0;
    rsp_o.ok   = 1'b0;
    rsp_o.data = '0;
    if (fire_i) begin
      case (req_i.op)
        spfq_pkg::OP_PUSH: begin
          if (prio_ok && (total_q != spfq_pkg::cnt_t'(CAP))) begin
            free_d  = free_link;
            data_we = 1'b1;
            if (occ_q[lv]) begin
              link_we    = 1'b1;
              link_waddr = last_rd;
              link_wdata = free_q;
            end else begin
              first_d[lv] = free_q;
              occ_d[lv]   = 1'b1;
            end
            last_d[lv] = free_q;
            total_d    = spfq_pkg::cnt_t'(total_q + spfq_pkg::cnt_t'(1));
            rsp_o.ok   = 1'b1;
          end
        end
        spfq_pkg::OP_POP, spfq_pkg::OP_PEEK: begin
          if (top_vld_q) begin
            rsp_o.ok   = 1'b1;
            rsp_o.data = data_rd;
            if (req_i.op == spfq_pkg::OP_POP) begin
              if (head_q == last_rd) begin
                occ_d[top_q] = 1'b0;
              end else begin
                first_d[top_q] = pop_link;
              end
              link_we    = 1'b1;
              link_waddr = head_q;
              link_wdata = free_q;
              free_d     = head_q;
              if (total_q != '0) begin
                total_d = spfq_pkg::cnt_t'(total_q - spfq_pkg::cnt_t'(1));
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    rsp_o.empty = (total_d == '0);
  end

  always_comb begin
    link_vld_d = link_vld_q;
    if (link_we) begin
      link_vld_d[link_waddr] = 1'b1;
    end
  end

  spfq_prio_enc u_prio_enc (
    .occ_i   (occ_d),
    .top_o   (top_d),
    .found_o (top_vld_d)
  );

  assign head_d = first_d[top_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q     <= '0;
      first_q    <= '{default: '0};
      last_q     <= '{default: '0};
      occ_q      <= '0;
      total_q    <= '0;
      top_q      <= '0;
      top_vld_q  <= 1'b0;
      head_q     <= '0;
      link_vld_q <= '0;
      free_vld_q <= 1'b0;
      pop_vld_q  <= 1'b0;
    end else begin
      free_q     <= free_d;
      first_q    <= first_d;
      last_q     <= last_d;
      occ_q      <= occ_d;
      total_q    <= total_d;
      top_q      <= top_d;
      top_vld_q  <= top_vld_d;
      head_q     <= head_d;
      link_vld_q <= link_vld_d;
      free_vld_q <= link_vld_d[free_d];
      pop_vld_q  <= link_vld_d[head_d];
    end
  end

  spfq_ram #(
    .WIDTH (spfq_pkg::DATA_WIDTH),
    .DEPTH (CAP)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (free_q),
    .wdata_i (req_i.payload),
    .raddr_i (head_d),
    .rdata_o (data_rd)
  );

  // Two copies of the link store, written alike, read at the free head and
  // at the served head.
  spfq_ram #(
    .WIDTH (spfq_pkg::SLOT_W),
    .DEPTH (CAP)
  ) u_link_free_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (free_d),
    .rdata_o (free_rd)
  );

  spfq_ram #(
    .WIDTH (spfq_pkg::SLOT_W),
    .DEPTH (CAP)
  ) u_link_pop_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (head_d),
    .rdata_o (pop_rd)
  );

endmodule

// ===== rtl/strict_priority_fifo_queue_unit.sv =====
// ---------------------------------------------------------------------------
// strict_priority_fifo_queue_unit: strict-priority multilevel FIFO queue
// Path: input register, then result register. Throughput: one transaction
// per cycle while results drain; the link and data RAM reads for the next
// operation are issued from the next-state pointers each cycle.
// Reset: asynchronous, active low; clears control state and link valid
// bits, so the free list reads as the index chain at once (no clearing pass).
// ---------------------------------------------------------------------------
module strict_priority_fifo_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spfq_pkg::OP_W-1:0]   opcode_i,
  input  logic [spfq_pkg::PRIO_W-1:0] priority_req_i,
  input  spfq_pkg::data_t             payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output spfq_pkg::data_t             entry_data_o,
  output logic                        now_empty_o
);

  // Input register: holds one accepted transaction until it is processed.
  logic           in_valid_q, in_valid_d;
  spfq_pkg::req_t in_q;

  // Result register: parts the core from the output handshake.
  logic           out_valid_q, out_valid_d;
  spfq_pkg::rsp_t out_q;
  spfq_pkg::rsp_t rsp;

  logic in_accept;
  logic fire;

  // Process the held transaction whenever the result slot is free or drains.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on handshake, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.op      <= opcode_i;
      in_q.prio    <= priority_req_i;
      in_q.payload <= payload_i;
    end
    if (fire) begin
      out_q <= rsp;
    end
  end

  // Queue state, slot pool and the single-pass update.
  spfq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_q.ok;
  assign entry_data_o = out_q.data;
  assign now_empty_o  = out_q.empty;

endmodule

// ===== rtl/spfq_checker.sv =====
// ---------------------------------------------------------------------------
// spfq_checker: port-level checks of the strict-priority FIFO queue
// Watches both handshakes and the result fields over time.
// ---------------------------------------------------------------------------
module spfq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [spfq_pkg::OP_W-1:0]   opcode_i,
  input logic [spfq_pkg::PRIO_W-1:0] priority_req_i,
  input spfq_pkg::data_t             payload_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        ok_o,
  input spfq_pkg::data_t             entry_data_o,
  input logic                        now_empty_o
);

  // Hold a waiting input transaction.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(opcode_i) && $stable(priority_req_i) && $stable(payload_i))
    else $error("waiting input changed");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(ok_o) && $stable(entry_data_o) && $stable(now_empty_o))
    else $error("stalled result changed");

  // Returned data only comes with success.
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_data_o != '0) |-> ok_o)
    else $error("nonzero entry data without ok");

  // Input backs up only behind a stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

  // A fresh result follows an accepted input transaction, through the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input transaction");

endmodule

bind strict_priority_fifo_queue_unit spfq_checker u_spfq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .opcode_i       (opcode_i),
  .priority_req_i (priority_req_i),
  .payload_i      (payload_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ok_o           (ok_o),
  .entry_data_o   (entry_data_o),
  .now_empty_o    (now_empty_o)
);
